// ===== rtl/core/bmss_pkg.sv =====
// shared types and constants of the boyer-moore scan step core
`timescale 1ns / 1ps

package bmss_pkg;

  localparam int unsigned ALPHABET_SIZE = 256;

  localparam int unsigned POS_W   = 25;
  localparam int unsigned LEN_W   = 24;
  localparam int unsigned PLEN_W  = 7;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned CMP_W   = 64;
  localparam int unsigned REQ_W   = 3;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOAD_PAT   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_SKIP  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_LOAD_SHIFT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_START      = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SCAN       = 3'd4;

  // configuration register indexes
  localparam logic CFG_PATTERN_LENGTH = 1'b0;
  localparam logic CFG_TEXT_LENGTH    = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0]  text_pos;
    logic [PLEN_W-1:0] pat_pos;
    logic [CNT_W-1:0]  match_cnt;
  } bmss_state_t;

  typedef struct packed {
    logic              compared;
    logic              found;
    logic [LEN_W-1:0]  where;
  } bmss_event_t;

endpackage

// ===== rtl/core/bmss_if.sv =====
// valid/ready channel interfaces for request and result items
`timescale 1ns / 1ps

interface bmss_req_if
  import bmss_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [BYTE_W-1:0] entry_index;
  logic [BYTE_W-1:0] entry_value;
  logic [BYTE_W-1:0] text_byte;

  modport source (output valid, req_type, entry_index, entry_value, text_byte,
                  input ready);
  modport sink   (input valid, req_type, entry_index, entry_value, text_byte,
                  output ready);
endinterface

interface bmss_res_if
  import bmss_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  next_index;
  logic              match_found;
  logic [LEN_W-1:0]  match_position;
  logic [PLEN_W-1:0] pattern_index;
  logic [CNT_W-1:0]  matches_total;
  logic              scan_done;

  modport source (output valid, next_index, match_found, match_position,
                  pattern_index, matches_total, scan_done, input ready);
  modport sink   (input valid, next_index, match_found, match_position,
                  pattern_index, matches_total, scan_done, output ready);
endinterface

// ===== rtl/core/bmss_ram.sv =====
// generic synchronous ram, one write port with byte enables, registered read
`timescale 1ns / 1ps

module bmss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [WIDTH/8-1:0]       be_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  localparam int unsigned NBYTES = WIDTH / 8;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int b = 0; b < NBYTES; b++) begin
        if (be_i[b]) begin
          mem_q[waddr_i][b*8 +: 8] <= wdata_i[b*8 +: 8];
        end
      end
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bmss_step.sv =====
// next-state logic of one start or scan item
`timescale 1ns / 1ps

module bmss_step
  import bmss_pkg::*;
(
  input  bmss_state_t       cur_i,
  input  logic              is_start_i,
  input  logic              is_scan_i,
  input  logic [PLEN_W-1:0] eff_len_i,
  input  logic [LEN_W-1:0]  text_len_i,
  input  logic [BYTE_W-1:0] text_byte_i,
  input  logic [BYTE_W-1:0] pat_byte_i,
  input  logic [BYTE_W-1:0] shift_i,
  input  logic [BYTE_W-1:0] skip_i,
  output bmss_state_t       nxt_o,
  output bmss_event_t       evt_o
);

  logic              done;
  logic [POS_W-1:0]  pd;
  logic [PLEN_W-1:0] p;
  logic              eq;
  logic [BYTE_W-1:0] jump;

  assign done = cur_i.text_pos > {1'b0, text_len_i};
  assign pd   = cur_i.text_pos - POS_W'(1);
  assign p    = cur_i.pat_pos - PLEN_W'(1);
  assign eq   = text_byte_i == pat_byte_i;
  assign jump = (shift_i > skip_i) ? shift_i : skip_i;

  always_comb begin
    nxt_o = cur_i;
    evt_o = '0;
    if (is_start_i) begin
      nxt_o.text_pos = POS_W'(eff_len_i);
      nxt_o.pat_pos  = eff_len_i;
    end else if (is_scan_i && (cur_i.pat_pos != '0) && !done) begin
      evt_o.compared = 1'b1;
      if (eq && (p != '0)) begin
        nxt_o.text_pos = pd;
        nxt_o.pat_pos  = p;
      end else begin
        nxt_o.text_pos = pd + POS_W'(jump);
        nxt_o.pat_pos  = eff_len_i;
        if (eq) begin
          evt_o.found = 1'b1;
          evt_o.where = pd[LEN_W-1:0];
          if (cur_i.match_cnt != '1) begin
            nxt_o.match_cnt = cur_i.match_cnt + CNT_W'(1);
          end
        end
      end
    end
  end

endmodule

// ===== rtl/core/boyer_moore_scan_step_core.sv =====
// top level of the boyer-moore scan step core
`timescale 1ns / 1ps

// channel   dir  handshake        payload
// in_i      in   valid / ready    req_type, entry_index, entry_value, text_byte
// out_o     out  valid / ready    next_index, match_found, match_position,
//                                 pattern_index, matches_total, scan_done
// cfg       in   cfg_we_i         cfg_index_i, cfg_data_i (no read-back)
//
// a load writes its table entry at the accept edge; for a scan item that edge
// issues the ram reads (pattern byte and good-suffix entry at the pattern index,
// bad-character entry at the text byte) and a later edge, once the output
// register is free, applies the registered read data
// one item is in flight at a time; a new item is taken only after it finishes
// a finished result waits in the output register while the next item is taken;
// a full output register holds the item in flight
// reset clears position, pattern index and counters; the rams are not cleared

module boyer_moore_scan_step_core
  import bmss_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  bmss_req_if.sink        in_i,
  bmss_res_if.source      out_o,
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [LEN_W-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_PATTERN);
  localparam int unsigned BW = $clog2(ALPHABET_SIZE);

  // configuration
  logic [PLEN_W-1:0] pat_len_q;
  logic [LEN_W-1:0]  text_len_q;
  logic [PLEN_W-1:0] eff_len;

  // scan state
  bmss_state_t       st_q, st_d;
  bmss_event_t       evt;
  logic [CMP_W-1:0]  cmp_cnt_q;

  // item in flight
  logic              busy_q;
  logic [REQ_W-1:0]  req_q;
  logic [BYTE_W-1:0] tb_q;

  // output register
  logic              out_valid_q;
  logic [POS_W-1:0]  next_index_q;
  logic              found_q;
  logic [LEN_W-1:0]  where_q;
  logic [PLEN_W-1:0] pidx_q;
  logic [CNT_W-1:0]  total_q;
  logic              done_q;

  logic              accept;
  logic              finish;
  logic              in_range;
  logic              wr_pat, wr_shift, wr_skip;
  logic [AW-1:0]     pg_raddr;
  logic [2*BYTE_W-1:0] pg_rdata;
  logic [BYTE_W-1:0] bc_rdata;
  logic [8:0]        idx_ext;

  // pattern length clipped to the store depth
  assign eff_len = ({2'b00, pat_len_q} > 9'(MAX_PATTERN)) ? PLEN_W'(MAX_PATTERN)
                                                          : pat_len_q;

  assign in_i.ready = !busy_q;
  assign accept     = in_i.valid && !busy_q;
  assign finish     = busy_q && (!out_valid_q || out_o.ready);

  // loads write straight away at the accept edge
  assign idx_ext  = {1'b0, in_i.entry_index};
  assign in_range = idx_ext < 9'(MAX_PATTERN);
  assign wr_pat   = accept && (in_i.req_type == REQ_LOAD_PAT) && in_range;
  assign wr_shift = accept && (in_i.req_type == REQ_LOAD_SHIFT) && in_range;
  assign wr_skip  = accept && (in_i.req_type == REQ_LOAD_SKIP);

  // pattern index stays put until the item in flight finishes
  assign pg_raddr = AW'(st_q.pat_pos - PLEN_W'(1));

  // low byte pattern, high byte good-suffix shift
  bmss_ram #(
    .WIDTH (2*BYTE_W),
    .DEPTH (MAX_PATTERN)
  ) u_pat_gs_ram (
    .clk_i   (clk_i),
    .we_i    (wr_pat || wr_shift),
    .be_i    ({wr_shift, wr_pat}),
    .waddr_i (AW'(in_i.entry_index)),
    .wdata_i ({in_i.entry_value, in_i.entry_value}),
    .re_i    (accept && (in_i.req_type == REQ_SCAN)),
    .raddr_i (pg_raddr),
    .rdata_o (pg_rdata)
  );

  bmss_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (ALPHABET_SIZE)
  ) u_bc_ram (
    .clk_i   (clk_i),
    .we_i    (wr_skip),
    .be_i    (1'b1),
    .waddr_i (BW'(in_i.entry_index)),
    .wdata_i (in_i.entry_value),
    .re_i    (accept && (in_i.req_type == REQ_SCAN)),
    .raddr_i (BW'(in_i.text_byte)),
    .rdata_o (bc_rdata)
  );

  bmss_step u_step (
    .cur_i       (st_q),
    .is_start_i  (req_q == REQ_START),
    .is_scan_i   (req_q == REQ_SCAN),
    .eff_len_i   (eff_len),
    .text_len_i  (text_len_q),
    .text_byte_i (tb_q),
    .pat_byte_i  (pg_rdata[BYTE_W-1:0]),
    .shift_i     (pg_rdata[2*BYTE_W-1:BYTE_W]),
    .skip_i      (bc_rdata),
    .nxt_o       (st_d),
    .evt_o       (evt)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q  <= PLEN_W'(1);
      text_len_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PATTERN_LENGTH: pat_len_q  <= cfg_data_i[PLEN_W-1:0];
        CFG_TEXT_LENGTH:    text_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
      cmp_cnt_q   <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
        if (evt.compared) begin
          cmp_cnt_q <= cmp_cnt_q + CMP_W'(1);
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload of the item in flight and of the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_i.req_type;
      tb_q  <= in_i.text_byte;
    end
    if (finish) begin
      next_index_q <= st_d.text_pos - POS_W'(1);
      found_q      <= evt.found;
      where_q      <= evt.where;
      pidx_q       <= st_d.pat_pos;
      total_q      <= st_d.match_cnt;
      done_q       <= st_d.text_pos > {1'b0, text_len_q};
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.next_index     = next_index_q;
  assign out_o.match_found    = found_q;
  assign out_o.match_position = where_q;
  assign out_o.pattern_index  = pidx_q;
  assign out_o.matches_total  = total_q;
  assign out_o.scan_done      = done_q;

endmodule
